/* rtl/core/lhti_pkg.sv */
// Shared types and constants of the linear hash table insert unit.
`default_nettype none
package lhti_pkg;

	localparam int MAX_BUCKETS_DEF      = 64;
	localparam int SLOTS_PER_BUCKET_DEF = 32;
	localparam int KEY_BITS             = 16;
	localparam int HANDLE_BITS          = 16;
	localparam int CFG_BITS             = 5;
	localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd4;

	localparam int PADDR_BITS = 3;
	localparam logic [PADDR_BITS-1:0] ADDR_INIT_BUCKETS = 3'd0;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_DROP  = 2'd1;
	localparam logic [1:0] STAT_TFULL = 2'd2;

	typedef struct packed {
		logic [KEY_BITS-1:0]    rec_key;
		logic [HANDLE_BITS-1:0] record_handle;
	} cmd_t;

	typedef struct packed {
		logic [5:0] stored_bucket;
		logic       split_done;
		logic [5:0] next_split;
		logic [2:0] round_level;
		logic [1:0] status;
	} res_t;

endpackage
`default_nettype wire

/* rtl/core/lhti_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module lhti_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic                 re,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

/* rtl/core/lhti_mod.sv */
// Bit-serial remainder unit: key mod divisor plus the low quotient bit.
`default_nettype none
module lhti_mod #(
	parameter int DW = 7
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [lhti_pkg::KEY_BITS-1:0] key,
	input  wire logic [DW-1:0]                divisor,
	output logic                              done,
	output logic      [DW-1:0]                rem,
	output logic                              q_lsb
);
	localparam int KB = lhti_pkg::KEY_BITS;
	localparam int NW = $clog2(KB + 1);

	logic [KB-1:0] key_q;
	logic [DW-1:0] div_q;
	logic [NW-1:0] cnt_q;
	logic          run_q;
	logic [DW:0]   trial;
	logic          ge;

	assign trial = {rem, key_q[KB-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= NW'(KB);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
			div_q <= divisor;
			rem   <= '0;
			q_lsb <= 1'b0;
		end else if (run_q) begin
			key_q <= key_q << 1;
			rem   <= ge ? DW'(trial - {1'b0, div_q}) : DW'(trial);
			q_lsb <= ge;
		end
	end
endmodule
`default_nettype wire

/* rtl/core/linear_hash_table_insert_unit.sv */
// Top level of the linear hash table insert unit: control, counts and entry store.
//   channel | dir | handshake            | payload
//   cmd     | in  | cmd_valid/cmd_ready  | lhti_pkg::cmd_t (rec_key, record_handle)
//   res     | out | res_valid/res_ready  | lhti_pkg::res_t (one beat per cmd beat)
//   apb     | in  | psel/penable/pready  | initial_buckets at address 0
// One item at a time. A split walks the C entries of the split bucket and runs the
// bit-serial remainder unit once per entry. No clearing pass: count valid bits reset
// at once. A waiting result does not block the next beat; the next result waits for it.
`default_nettype none
module linear_hash_table_insert_unit #(
	parameter int MAX_BUCKETS      = lhti_pkg::MAX_BUCKETS_DEF,
	parameter int SLOTS_PER_BUCKET = lhti_pkg::SLOTS_PER_BUCKET_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [lhti_pkg::PADDR_BITS-1:0]   paddr,
	input  wire logic [31:0]                       pwdata,
	output logic      [31:0]                       prdata,
	output logic                                   pready,
	input  wire logic                              cmd_valid,
	output logic                                   cmd_ready,
	input  wire lhti_pkg::cmd_t                    cmd,
	output logic                                   res_valid,
	input  wire logic                              res_ready,
	output lhti_pkg::res_t                         res
);
	localparam int KB = lhti_pkg::KEY_BITS;
	localparam int HB = lhti_pkg::HANDLE_BITS;
	localparam int EW = KB + HB;
	localparam int BW = $clog2(MAX_BUCKETS);
	localparam int MW = $clog2(MAX_BUCKETS + 1);
	localparam int RW = $clog2($clog2(MAX_BUCKETS) + 1);
	localparam int SW = $clog2(SLOTS_PER_BUCKET);
	localparam int CW = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int AW = $clog2(MAX_BUCKETS * SLOTS_PER_BUCKET);
	localparam int CB = lhti_pkg::CFG_BITS;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_HDIV  = 11'b000_0000_0010,
		ST_HRD   = 11'b000_0000_0100,
		ST_SCNT  = 11'b000_0000_1000,
		ST_SCNT2 = 11'b000_0001_0000,
		ST_ERD   = 11'b000_0010_0000,
		ST_EDIV  = 11'b000_0100_0000,
		ST_EWAIT = 11'b000_1000_0000,
		ST_FIN   = 11'b001_0000_0000,
		ST_FIN2  = 11'b010_0000_0000,
		ST_DONE  = 11'b100_0000_0000
	} state_t;

	function automatic logic [MW-1:0] base_n(input logic [CB-1:0] c);
		logic [MW-1:0] r;
		if (c == '0) begin
			r = MW'(1);
		end else if (32'(c) > MAX_BUCKETS) begin
			r = MW'(MAX_BUCKETS);
		end else begin
			r = MW'(c);
		end
		return r;
	endfunction

	function automatic logic [AW-1:0] slot_addr(input logic [BW-1:0] b, input logic [SW-1:0] s);
		return AW'(AW'(b) * AW'(SLOTS_PER_BUCKET) + AW'(s));
	endfunction

	state_t          st_q;
	logic [CB-1:0]   cfg_q;
	logic [BW-1:0]   sp_q;
	logic [RW-1:0]   round_q;
	logic [MW-1:0]   total_q;
	logic [MAX_BUCKETS-1:0] vld_q;
	logic [KB-1:0]   key_q;
	logic [HB-1:0]   handle_q;
	logic [BW-1:0]   home_q;
	logic [MW:0]     km2_q;
	logic [1:0]      status_q;
	logic            split_q;
	logic [BW-1:0]   placed_q;
	logic [CW-1:0]   cnt_s_q;
	logic [CW-1:0]   i_q;
	logic [CW-1:0]   keep_q;
	logic [CW-1:0]   dcnt_q;
	logic [EW-1:0]   ent_q;

	logic [MW-1:0]   n;
	logic [MW-1:0]   m;
	logic            cfg_wr;
	logic            cmd_acc;
	logic [BW-1:0]   dst;

	logic            div_start;
	logic [KB-1:0]   div_key;
	logic            div_done;
	logic [MW-1:0]   div_rem;
	logic            div_q;
	logic [MW:0]     mod2;
	logic [MW:0]     home_pre;
	logic [BW-1:0]   home_c;

	logic            cnt_we;
	logic [BW-1:0]   cnt_waddr;
	logic [CW-1:0]   cnt_wdata;
	logic            cnt_re;
	logic [BW-1:0]   cnt_raddr;
	logic [CW-1:0]   cnt_rdata;
	logic [CW-1:0]   cnt_home;
	logic [CW-1:0]   cnt_sp;

	logic            ent_we;
	logic [AW-1:0]   ent_waddr;
	logic [EW-1:0]   ent_wdata;
	logic            ent_re;
	logic [EW-1:0]   ent_rdata;

	assign n       = base_n(cfg_q);
	assign m       = MW'(n << round_q);
	assign cfg_wr  = psel && penable && pwrite && pready && paddr == lhti_pkg::ADDR_INIT_BUCKETS;
	assign pready  = 1'b1;
	assign prdata  = (paddr == lhti_pkg::ADDR_INIT_BUCKETS) ? 32'(cfg_q) : 32'd0;
	assign cmd_ready = st_q == ST_IDLE;
	assign cmd_acc = cmd_valid && cmd_ready;
	assign dst     = total_q[BW-1:0];

	// key mod 2m follows from key mod m and the parity of the quotient
	assign mod2     = (MW+1)'(div_rem) + (div_q ? (MW+1)'(m) : '0);
	assign home_pre = ((MW+1)'(div_rem) < (MW+1)'(sp_q)) ? mod2 : (MW+1)'(div_rem);
	assign home_c   = (32'(home_pre) >= MAX_BUCKETS) ? BW'(MAX_BUCKETS - 1) : BW'(home_pre);
	assign cnt_home = vld_q[home_q] ? cnt_rdata : '0;
	assign cnt_sp   = vld_q[sp_q] ? cnt_rdata : '0;

	assign div_start = cmd_acc || st_q == ST_EDIV;
	assign div_key   = (st_q == ST_EDIV) ? ent_rdata[KB-1:0] : cmd.rec_key;

	lhti_mod #(.DW(MW)) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.key     (div_key),
		.divisor (m),
		.done    (div_done),
		.rem     (div_rem),
		.q_lsb   (div_q)
	);

	lhti_ram #(.W(CW), .D(MAX_BUCKETS)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	lhti_ram #(.W(EW), .D(MAX_BUCKETS * SLOTS_PER_BUCKET)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (slot_addr(sp_q, i_q[SW-1:0])),
		.rdata (ent_rdata)
	);

	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = home_q;
		cnt_wdata = cnt_home + 1'b1;
		cnt_re    = 1'b0;
		cnt_raddr = sp_q;
		ent_we    = 1'b0;
		ent_waddr = slot_addr(home_q, cnt_home[SW-1:0]);
		ent_wdata = {handle_q, key_q};
		ent_re    = st_q == ST_ERD;
		case (st_q)
			ST_HDIV: begin
				cnt_re    = div_done;
				cnt_raddr = home_c;
			end
			ST_HRD: begin
				cnt_we = 32'(cnt_home) < SLOTS_PER_BUCKET;
				ent_we = 32'(cnt_home) < SLOTS_PER_BUCKET;
			end
			ST_SCNT: begin
				cnt_re = 1'b1;
			end
			ST_EWAIT: begin
				ent_we    = div_done;
				ent_wdata = ent_q;
				if (mod2 == (MW+1)'(sp_q)) begin
					ent_waddr = slot_addr(sp_q, keep_q[SW-1:0]);
				end else begin
					ent_waddr = slot_addr(dst, dcnt_q[SW-1:0]);
				end
			end
			ST_FIN: begin
				cnt_we    = 1'b1;
				cnt_waddr = sp_q;
				cnt_wdata = keep_q;
			end
			ST_FIN2: begin
				cnt_we    = 1'b1;
				cnt_waddr = dst;
				cnt_wdata = dcnt_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			cfg_q     <= lhti_pkg::CFG_RESET;
			sp_q      <= '0;
			round_q   <= '0;
			total_q   <= base_n(lhti_pkg::CFG_RESET);
			vld_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			if (st_q == ST_DONE && (!res_valid || res_ready)) begin
				res_valid <= 1'b1;
			end else if (res_valid && res_ready) begin
				res_valid <= 1'b0;
			end
			if (cnt_we) begin
				vld_q[cnt_waddr] <= 1'b1;
			end
			if (cfg_wr) begin
				cfg_q   <= pwdata[CB-1:0];
				sp_q    <= '0;
				round_q <= '0;
				total_q <= base_n(pwdata[CB-1:0]);
				vld_q   <= '0;
			end
			case (st_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						st_q <= ST_HDIV;
					end
				end
				ST_HDIV: begin
					if (div_done) begin
						st_q <= ST_HRD;
					end
				end
				ST_HRD: begin
					if (32'(cnt_home) >= 32'(n) && total_q < MW'(MAX_BUCKETS)) begin
						st_q <= ST_SCNT;
					end else begin
						st_q <= ST_DONE;
					end
				end
				ST_SCNT: st_q <= ST_SCNT2;
				ST_SCNT2: begin
					st_q <= (cnt_sp == '0) ? ST_FIN : ST_ERD;
				end
				ST_ERD:  st_q <= ST_EDIV;
				ST_EDIV: st_q <= ST_EWAIT;
				ST_EWAIT: begin
					if (div_done) begin
						st_q <= (i_q + 1'b1 == cnt_s_q) ? ST_FIN : ST_ERD;
					end
				end
				ST_FIN: st_q <= ST_FIN2;
				ST_FIN2: begin
					total_q <= total_q + 1'b1;
					if (MW'(sp_q) + 1'b1 >= m) begin
						sp_q    <= '0;
						round_q <= round_q + 1'b1;
					end else begin
						sp_q <= sp_q + 1'b1;
					end
					st_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_valid || res_ready) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				key_q    <= cmd.rec_key;
				handle_q <= cmd.record_handle;
				split_q  <= 1'b0;
			end
			ST_HDIV: begin
				home_q   <= home_c;
				placed_q <= home_c;
				km2_q    <= mod2;
			end
			ST_HRD: begin
				if (32'(cnt_home) >= SLOTS_PER_BUCKET) begin
					status_q <= lhti_pkg::STAT_DROP;
				end else if (32'(cnt_home) >= 32'(n) && total_q >= MW'(MAX_BUCKETS)) begin
					status_q <= lhti_pkg::STAT_TFULL;
				end else begin
					status_q <= lhti_pkg::STAT_OK;
				end
			end
			ST_SCNT2: begin
				cnt_s_q <= cnt_sp;
				i_q     <= '0;
				keep_q  <= '0;
				dcnt_q  <= '0;
			end
			ST_EDIV: ent_q <= ent_rdata;
			ST_EWAIT: begin
				if (div_done) begin
					i_q <= i_q + 1'b1;
					if (mod2 == (MW+1)'(sp_q)) begin
						keep_q <= keep_q + 1'b1;
					end else begin
						dcnt_q <= dcnt_q + 1'b1;
					end
				end
			end
			ST_FIN2: begin
				split_q <= 1'b1;
				if (status_q == lhti_pkg::STAT_OK && home_q == sp_q &&
				    km2_q != (MW+1)'(sp_q)) begin
					placed_q <= dst;
				end
			end
			ST_DONE: begin
				if (!res_valid || res_ready) begin
					res.stored_bucket <= 6'(placed_q);
					res.split_done    <= split_q;
					res.next_split    <= 6'(sp_q);
					res.round_level   <= 3'(round_q);
					res.status        <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(total_q) <= MAX_BUCKETS)
		else $error("bucket total beyond table");

	a_sp_below_m: assert property (@(posedge clk) disable iff (!arst_n)
		MW'(sp_q) < m)
		else $error("split pointer not below round size");

	a_split_tally: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ERD || st_q == ST_FIN) |->
		(CW+1)'(keep_q) + (CW+1)'(dcnt_q) == (CW+1)'(i_q))
		else $error("split kept plus moved differs from entries walked");

	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(st_q == ST_DONE))
		else $error("result beat raised outside completion");
endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Testbench for the linear hash table insert unit: directed table, random inserts, predictor.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

	localparam int NBKT = 64;
	localparam int NSLOT = 32;
	localparam int RAND_ITEMS = 1260;
	localparam longint CYCLE_LIMIT = 64'd10000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [lhti_pkg::PADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	lhti_pkg::cmd_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	lhti_pkg::res_t res;

	linear_hash_table_insert_unit dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow of the table
	logic [4:0]  cfg_buckets;
	logic [31:0] slot_mem [NBKT*NSLOT];
	int unsigned fill [NBKT];
	int unsigned split_ptr, round_cnt, bkt_total;

	lhti_pkg::res_t expected_q[$];
	int errors = 0;
	int inserts = 0, splits = 0, drops = 0, tfulls = 0, results_seen = 0;
	longint cycles = 0;
	logic stall_lock = 1'b0; // holds the receiver ready during drain phases

	function automatic int unsigned eff_buckets();
		int unsigned n;
		n = cfg_buckets;
		if (n == 0) n = 1;
		if (n > NBKT) n = NBKT;
		return n;
	endfunction

	function automatic void clear_table();
		for (int i = 0; i < NBKT; i++) fill[i] = 0;
		split_ptr = 0;
		round_cnt = 0;
		bkt_total = eff_buckets();
	endfunction

	function automatic lhti_pkg::res_t predict_insert(logic [15:0] key, logic [15:0] hdl);
		lhti_pkg::res_t r;
		int unsigned n, home, placed, st, dst, keep, cnt, s;
		longint unsigned m, m2;
		bit ovf, did_split;
		logic [31:0] e;
		n = eff_buckets();
		m = longint'(n) << round_cnt;
		m2 = m << 1;
		home = key % m;
		if (home < split_ptr) home = key % m2;
		if (home >= NBKT) home = NBKT - 1;
		placed = home;
		st = lhti_pkg::STAT_OK;
		did_split = 0;
		ovf = fill[home] >= n;
		if (fill[home] < NSLOT) begin
			slot_mem[home*NSLOT + fill[home]] = {hdl, key};
			fill[home]++;
		end else begin
			st = lhti_pkg::STAT_DROP;
		end
		if (ovf) begin
			if (bkt_total >= NBKT) begin
				if (st == lhti_pkg::STAT_OK) st = lhti_pkg::STAT_TFULL;
			end else begin
				s = split_ptr;
				dst = bkt_total;
				keep = 0;
				fill[dst] = 0;
				cnt = fill[s];
				for (int i = 0; i < cnt; i++) begin
					e = slot_mem[s*NSLOT + i];
					if ((e[15:0] % m2) == s) begin
						slot_mem[s*NSLOT + keep] = e;
						keep++;
					end else if (fill[dst] < NSLOT) begin
						slot_mem[dst*NSLOT + fill[dst]] = e;
						fill[dst]++;
					end
				end
				fill[s] = keep;
				if (st == lhti_pkg::STAT_OK && home == s && (key % m2) != s) placed = dst;
				did_split = 1;
				bkt_total++;
				split_ptr++;
				if (split_ptr >= m) begin
					split_ptr = 0;
					round_cnt++;
				end
			end
		end
		r.stored_bucket = placed[5:0];
		r.split_done = did_split;
		r.next_split = split_ptr[5:0];
		r.round_level = round_cnt[2:0];
		r.status = st[1:0];
		return r;
	endfunction

	function automatic int rand_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// valid stays up across back-to-back beats; it drops only before a gap
	task automatic send_insert(logic [15:0] key, logic [15:0] hdl);
		int g;
		g = rand_gap();
		if (g != 0) cmd_valid <= 1'b0;
		repeat (g) @(negedge clk);
		cmd.rec_key = key;
		cmd.record_handle = hdl;
		cmd_valid <= 1'b1;
		expected_q.insert(expected_q.size(), predict_insert(key, hdl));
		inserts++;
		do @(posedge clk); while (!cmd_ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		stall_lock = 1'b1;
		while (expected_q.size() != 0) @(negedge clk);
		stall_lock = 1'b0;
		// last result may come out before the unit is fully idle
		repeat (30) @(negedge clk);
	endtask

	task automatic write_buckets(logic [4:0] val);
		wait_drained();
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= lhti_pkg::ADDR_INIT_BUCKETS; pwdata <= {27'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		cfg_buckets = val;
		clear_table();
	endtask

	// result side: random stalls, checks each beat against the oldest expectation
	always @(negedge clk) begin
		if (stall_lock) res_ready <= 1'b1;
		else res_ready <= ($urandom_range(0, 99) < 12) ? 1'b0 :
			(($urandom_range(0, 99) < 3) ? 1'b0 : 1'b1);
	end

	always @(posedge clk) begin
		lhti_pkg::res_t exp_r;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout", $time);
			$display("testbench failed");
			$finish;
		end
		if (arst_n && res_valid && res_ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				$display("%0t unexpected beat %p", $time, res);
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				if (res !== exp_r) begin
					$display("%0t mismatch: expected %p actual %p", $time, exp_r, res);
					errors++;
				end
				if (res.split_done) splits++;
				if (res.status == lhti_pkg::STAT_DROP) drops++;
				if (res.status == lhti_pkg::STAT_TFULL) tfulls++;
			end
		end
	end

	typedef struct {
		logic [15:0] key;
		logic [15:0] hdl;
	} stim_row_t;

	stim_row_t dir_rows[] = '{
		'{16'h0000, 16'h0000}, '{16'hFFFF, 16'hFFFF}, '{16'h0004, 16'hAAAA},
		'{16'h0008, 16'h5555}, '{16'h000C, 16'h0001}, '{16'h0010, 16'h8000},
		'{16'h0001, 16'h1234}, '{16'h0005, 16'h4321}, '{16'hFFFE, 16'h00FF},
		'{16'h8000, 16'hFF00}, '{16'h7FFF, 16'h0F0F}, '{16'h0002, 16'hF0F0}
	};

	initial begin
		lhti_pkg::res_t r0;
		int phase_n;
		logic [15:0] k;
		cfg_buckets = lhti_pkg::CFG_RESET;
		clear_table();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// after reset: key 0 lands in bucket 0, plain ok
		r0 = predict_insert(16'h0000, 16'h0000);
		if (r0 !== lhti_pkg::res_t'{6'd0, 1'b0, 6'd0, 3'd0, lhti_pkg::STAT_OK}) begin
			$display("%0t mismatch: expected first-insert result, model gave %p", $time, r0);
			errors++;
		end
		cfg_buckets = lhti_pkg::CFG_RESET;
		clear_table();
		foreach (dir_rows[i]) send_insert(dir_rows[i].key, dir_rows[i].hdl);

		// zero count acts as one; every key into bucket 0 to overrun the slots
		write_buckets(5'd0);
		for (int i = 0; i < 40; i++) send_insert(16'(i * 64), $urandom);
		// flood with the largest count; under 31 buckets these keys spread over many homes
		write_buckets(5'd31);
		for (int i = 0; i < 60; i++) send_insert(16'(i * 128), $urandom);
		write_buckets(5'd16);
		for (int i = 0; i < 25; i++) send_insert(16'(i * 16), $urandom);

		// random phases across settings; small counts give many splits
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: write_buckets(5'd1);
				1: write_buckets(5'd2);
				9: write_buckets(5'd16);
				default: write_buckets(5'($urandom_range(0, 31)));
			endcase
			phase_n = RAND_ITEMS / 10;
			for (int i = 0; i < phase_n; i++) begin
				case ($urandom_range(0, 3))
					0: k = $urandom;
					1: k = 16'($urandom_range(0, 255));
					2: k = 16'($urandom_range(0, 7) * 64);
					default: k = ~16'($urandom_range(0, 255));
				endcase
				send_insert(k, $urandom);
				if (i == phase_n / 2) wait_drained();
			end
		end

		wait_drained();
		$display("inserts %0d, results %0d, splits %0d, dropped %0d, table-full %0d",
			inserts, results_seen, splits, drops, tfulls);
		$display("bucket counts 0, 1, 2, 16, 31 and random ones, with floods into one bucket");
		if (errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
rtl/core/lhti_pkg.sv
rtl/core/lhti_ram.sv
rtl/core/lhti_mod.sv
rtl/core/linear_hash_table_insert_unit.sv
tb/sv/testbench.sv
